// ===== rtl/tbvm_pkg.sv =====
// ----------------------------------------------------------------------------
// tbvm_pkg
// Shared widths, types and per-moment rounding constants for the tapered box
// volume moments core.
// ----------------------------------------------------------------------------
package tbvm_pkg;

	localparam int NUM_MOM = 10;
	localparam int IN_W    = 24;
	localparam int OUT_W   = 64;
	localparam int SUM_W   = 104;
	localparam int EXT_W   = 106;
	localparam int RED_W   = 72;

	typedef logic signed [IN_W-1:0]  side_t;
	typedef logic signed [SUM_W-1:0] sum_t;
	typedef logic signed [OUT_W-1:0] mom_t;

	// divisor = div << sh, div split as 2^e * odd; inv_m = 4095 / odd; recip = ceil(2^24 / odd)
	typedef struct packed {
		logic [8:0]  div;
		logic [4:0]  sh;
		logic [2:0]  e;
		logic [5:0]  odd;
		logic [10:0] inv_m;
		logic [22:0] recip;
	} rnd_const_t;

	// xx, xy, xz, x, yy, yz, y, zz, z, volume
	localparam rnd_const_t RND_K [NUM_MOM] = '{
		'{9'd360, 5'd30, 3'd3, 6'd45, 11'd91,   23'd372828},
		'{9'd480, 5'd30, 3'd5, 6'd15, 11'd273,  23'd1118482},
		'{9'd240, 5'd15, 3'd4, 6'd15, 11'd273,  23'd1118482},
		'{9'd48,  5'd15, 3'd4, 6'd3,  11'd1365, 23'd5592406},
		'{9'd360, 5'd30, 3'd3, 6'd45, 11'd91,   23'd372828},
		'{9'd240, 5'd15, 3'd4, 6'd15, 11'd273,  23'd1118482},
		'{9'd48,  5'd15, 3'd4, 6'd3,  11'd1365, 23'd5592406},
		'{9'd120, 5'd0,  3'd3, 6'd15, 11'd273,  23'd1118482},
		'{9'd24,  5'd0,  3'd3, 6'd3,  11'd1365, 23'd5592406},
		'{9'd6,   5'd0,  3'd1, 6'd3,  11'd1365, 23'd5592406}
	};

endpackage

// ===== rtl/tbvm_poly.sv =====
// ----------------------------------------------------------------------------
// tbvm_poly
// Six-stage pipeline forming the exact weighted Bernstein sums of all ten
// moments from the four side lengths.
// ----------------------------------------------------------------------------
module tbvm_poly import tbvm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  vld,
	input  side_t base_x,
	input  side_t base_y,
	input  side_t top_x,
	input  side_t top_y,
	output logic  vld_out,
	output sum_t  s [NUM_MOM]
);

	localparam int PW = 48;
	localparam int QW = 56;
	localparam int NT = 19;

	typedef logic signed [PW-1:0] pair_t;
	typedef logic signed [QW-1:0] quad_t;

	function automatic quad_t qf(input pair_t u, input pair_t v, input pair_t w,
		input logic signed [5:0] ku, input logic signed [5:0] kv,
		input logic signed [5:0] kw);
		qf = QW'(u) * QW'(ku) + QW'(v) * QW'(kv) + QW'(w) * QW'(kw);
	endfunction

	function automatic quad_t qf4(input pair_t u, input pair_t v, input pair_t w,
		input pair_t x, input logic signed [5:0] ku, input logic signed [5:0] kv,
		input logic signed [5:0] kw, input logic signed [5:0] kx);
		qf4 = QW'(u) * QW'(ku) + QW'(v) * QW'(kv) + QW'(w) * QW'(kw) + QW'(x) * QW'(kx);
	endfunction

	logic [5:0] vld_q;

	side_t a_s1, b_s1, c_s1, d_s1;
	side_t a_s2, b_s2, c_s2, d_s2;
	pair_t aa_s2, ab_s2, bb_s2, cc_s2, cd_s2, dd_s2, ac_s2, ad_s2, bc_s2, bd_s2;

	pair_t tp [NT];
	quad_t tq [NT];
	pair_t tp_s3 [NT];
	quad_t tq_s3 [NT];
	quad_t lz_s3 [3];
	quad_t lz_s4 [3];
	quad_t lz_s5 [3];

	logic signed [53:0] pll_s4 [NT];
	logic signed [52:0] plh_s4 [NT];
	logic signed [52:0] phl_s4 [NT];
	logic signed [51:0] phh_s4 [NT];
	sum_t term_s5 [NT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[4:0], vld};
		end
	end

	assign vld_out = vld_q[5];

	always_comb begin
		tp[0]  = ac_s2; tq[0]  = qf(aa_s2, ab_s2, bb_s2, 6'sd24, 6'sd18, 6'sd12);
		tp[1]  = bc_s2; tq[1]  = qf(aa_s2, ab_s2, bb_s2, 6'sd0,  6'sd0,  6'sd6);
		tp[2]  = ad_s2; tq[2]  = qf(aa_s2, ab_s2, bb_s2, 6'sd6,  6'sd0,  6'sd0);
		tp[3]  = bd_s2; tq[3]  = qf(aa_s2, ab_s2, bb_s2, 6'sd12, 6'sd18, 6'sd24);
		tp[4]  = cc_s2; tq[4]  = qf(aa_s2, ab_s2, bb_s2, 6'sd24, 6'sd12, 6'sd4);
		tp[5]  = cd_s2; tq[5]  = qf(aa_s2, ab_s2, bb_s2, 6'sd12, 6'sd16, 6'sd12);
		tp[6]  = dd_s2; tq[6]  = qf(aa_s2, ab_s2, bb_s2, 6'sd4,  6'sd12, 6'sd24);
		tp[7]  = PW'(c_s2); tq[7]  = qf(aa_s2, ab_s2, bb_s2, 6'sd6, 6'sd8,  6'sd6);
		tp[8]  = PW'(d_s2); tq[8]  = qf(aa_s2, ab_s2, bb_s2, 6'sd4, 6'sd12, 6'sd24);
		tp[9]  = PW'(c_s2); tq[9]  = qf(aa_s2, ab_s2, bb_s2, 6'sd6, 6'sd4,  6'sd2);
		tp[10] = PW'(d_s2); tq[10] = qf(aa_s2, ab_s2, bb_s2, 6'sd2, 6'sd4,  6'sd6);
		tp[11] = ac_s2; tq[11] = qf(cc_s2, cd_s2, dd_s2, 6'sd24, 6'sd18, 6'sd12);
		tp[12] = ad_s2; tq[12] = qf(cc_s2, cd_s2, dd_s2, 6'sd0,  6'sd0,  6'sd6);
		tp[13] = bc_s2; tq[13] = qf(cc_s2, cd_s2, dd_s2, 6'sd6,  6'sd0,  6'sd0);
		tp[14] = bd_s2; tq[14] = qf(cc_s2, cd_s2, dd_s2, 6'sd12, 6'sd18, 6'sd24);
		tp[15] = PW'(a_s2); tq[15] = qf(cc_s2, cd_s2, dd_s2, 6'sd6, 6'sd8,  6'sd6);
		tp[16] = PW'(b_s2); tq[16] = qf(cc_s2, cd_s2, dd_s2, 6'sd4, 6'sd12, 6'sd24);
		tp[17] = PW'(a_s2); tq[17] = qf(cc_s2, cd_s2, dd_s2, 6'sd6, 6'sd4,  6'sd2);
		tp[18] = PW'(b_s2); tq[18] = qf(cc_s2, cd_s2, dd_s2, 6'sd2, 6'sd4,  6'sd6);
	end

	always_ff @(posedge clk) begin
		a_s1 <= base_x;
		b_s1 <= top_x;
		c_s1 <= base_y;
		d_s1 <= top_y;

		a_s2  <= a_s1;
		b_s2  <= b_s1;
		c_s2  <= c_s1;
		d_s2  <= d_s1;
		aa_s2 <= a_s1 * a_s1;
		ab_s2 <= a_s1 * b_s1;
		bb_s2 <= b_s1 * b_s1;
		cc_s2 <= c_s1 * c_s1;
		cd_s2 <= c_s1 * d_s1;
		dd_s2 <= d_s1 * d_s1;
		ac_s2 <= a_s1 * c_s1;
		ad_s2 <= a_s1 * d_s1;
		bc_s2 <= b_s1 * c_s1;
		bd_s2 <= b_s1 * d_s1;

		tp_s3 <= tp;
		tq_s3 <= tq;
		lz_s3[0] <= qf4(ac_s2, bc_s2, ad_s2, bd_s2, 6'sd4, 6'sd6, 6'sd6, 6'sd24);
		lz_s3[1] <= qf4(ac_s2, bc_s2, ad_s2, bd_s2, 6'sd2, 6'sd2, 6'sd2, 6'sd6);
		lz_s3[2] <= qf4(ac_s2, bc_s2, ad_s2, bd_s2, 6'sd2, 6'sd1, 6'sd1, 6'sd2);

		for (int i = 0; i < NT; i++) begin
			pll_s4[i] <= $signed({1'b0, tp_s3[i][23:0]}) * $signed({1'b0, tq_s3[i][27:0]});
			plh_s4[i] <= $signed({1'b0, tp_s3[i][23:0]}) * $signed(tq_s3[i][QW-1:28]);
			phl_s4[i] <= $signed(tp_s3[i][PW-1:24]) * $signed({1'b0, tq_s3[i][27:0]});
			phh_s4[i] <= $signed(tp_s3[i][PW-1:24]) * $signed(tq_s3[i][QW-1:28]);
		end
		lz_s4 <= lz_s3;

		for (int i = 0; i < NT; i++) begin
			term_s5[i] <= (SUM_W'(phh_s4[i]) <<< 52) + (SUM_W'(phl_s4[i]) <<< 24)
				+ (SUM_W'(plh_s4[i]) <<< 28) + SUM_W'(pll_s4[i]);
		end
		lz_s5 <= lz_s4;

		s[0] <= term_s5[0] + term_s5[1] + term_s5[2] + term_s5[3];
		s[1] <= term_s5[4] + term_s5[5] + term_s5[6];
		s[2] <= term_s5[7] + term_s5[8];
		s[3] <= term_s5[9] + term_s5[10];
		s[4] <= term_s5[11] + term_s5[12] + term_s5[13] + term_s5[14];
		s[5] <= term_s5[15] + term_s5[16];
		s[6] <= term_s5[17] + term_s5[18];
		s[7] <= SUM_W'(lz_s5[0]);
		s[8] <= SUM_W'(lz_s5[1]);
		s[9] <= SUM_W'(lz_s5[2]);
	end

endmodule

// ===== rtl/tbvm_round.sv =====
// ----------------------------------------------------------------------------
// tbvm_round
// Ten-stage pipeline: round to nearest, floor divide by a small constant
// (power-of-two shift, remainder by 12-bit chunk folding, exact division by
// the odd part) and saturate to 64 bits.
// ----------------------------------------------------------------------------
module tbvm_round import tbvm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       vld,
	input  sum_t       s,
	input  rnd_const_t k,
	output logic       vld_out,
	output mom_t       value,
	output logic       sat
);

	logic [9:0] vld_q;

	logic signed [EXT_W-1:0] dw, tw, lim, b_s1;
	logic [5:0]  sa;
	logic [1:0]  clip_s2, clip_s3, clip_s4, clip_s5, clip_s6, clip_s7, clip_s8, clip_s9;
	logic [RED_W-1:0] u_s2, u_s3, u_s4, y_s5, t_s7, u1, u2_s8, u3_s9, q;
	logic [14:0] csum;
	logic [12:0] f_next, f_s3, f_s4, rem;
	logic [35:0] fm;
	logic [11:0] qq_s4;
	logic [34:0] py_s6 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[8:0], vld};
		end
	end

	assign vld_out = vld_q[9];

	assign dw  = signed'(EXT_W'(k.div) << k.sh);
	assign tw  = (EXT_W'(s) <<< 1) + dw;
	assign sa  = 6'(k.sh) + 6'(k.e) + 6'd1;
	assign lim = signed'(EXT_W'(k.odd) << (OUT_W - 1));

	always_comb begin
		csum = '0;
		for (int i = 0; i < 6; i++) begin
			csum = csum + 15'(u_s2[12*i +: 12]);
		end
		f_next = 13'(csum[11:0]) + 13'(csum[14:12]);
	end

	assign fm  = 36'(f_s3) * 36'(k.recip);
	assign rem = f_s4 - 13'(18'(qq_s4) * 18'(k.odd));
	assign u1  = t_s7 + (t_s7 << 12);
	assign q   = RED_W'(0) - u3_s9;

	always_ff @(posedge clk) begin
		b_s1 <= tw >>> sa;

		clip_s2 <= {b_s1 >= lim, b_s1 < -lim};
		u_s2    <= RED_W'(b_s1 + lim);

		clip_s3 <= clip_s2;
		u_s3    <= u_s2;
		f_s3    <= f_next;

		clip_s4 <= clip_s3;
		u_s4    <= u_s3;
		f_s4    <= f_s3;
		qq_s4   <= fm[35:24];

		clip_s5 <= clip_s4;
		y_s5    <= u_s4 - RED_W'(rem);

		clip_s6 <= clip_s5;
		for (int i = 0; i < 3; i++) begin
			py_s6[i] <= 35'(y_s5[24*i +: 24]) * 35'(k.inv_m);
		end

		clip_s7 <= clip_s6;
		t_s7    <= (RED_W'(py_s6[2]) << 48) + (RED_W'(py_s6[1]) << 24) + RED_W'(py_s6[0]);

		clip_s8 <= clip_s7;
		u2_s8   <= u1 + (u1 << 24);

		clip_s9 <= clip_s8;
		u3_s9   <= u2_s8 + (u2_s8 << 48);

		sat <= |clip_s9;
		if (clip_s9[1]) begin
			value <= {1'b0, {(OUT_W-1){1'b1}}};
		end else if (clip_s9[0]) begin
			value <= {1'b1, {(OUT_W-1){1'b0}}};
		end else begin
			value <= {~q[OUT_W-1], q[OUT_W-2:0]};
		end
	end

endmodule

// ===== rtl/tapered_box_volume_moments_core.sv =====
// ----------------------------------------------------------------------------
// tapered_box_volume_moments_core
// Volume moments of a tapered box of unit height: Q8.15 sides in, ten
// saturated Q33.30 moments out.
// ----------------------------------------------------------------------------
// done is high in the cycle in which the moments of a box taken on start are valid.
// Throughput: one box per cycle; busy stays low, the 16 register stages
// (6 polynomial, 10 round/divide) never stall as results cannot be held off.
// Reset clears only the valid bits of both pipelines; no transaction in flight
// survives it.
module tapered_box_volume_moments_core import tbvm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	output logic  busy,
	input  side_t base_x,
	input  side_t base_y,
	input  side_t top_x,
	input  side_t top_y,
	output logic  done,
	output mom_t  moment_xx,
	output mom_t  moment_xy,
	output mom_t  moment_xz,
	output mom_t  moment_x,
	output mom_t  moment_yy,
	output mom_t  moment_yz,
	output mom_t  moment_y,
	output mom_t  moment_zz,
	output mom_t  moment_z,
	output mom_t  volume,
	output logic  saturated
);

	logic             poly_vld;
	sum_t             sums [NUM_MOM];
	mom_t             mom  [NUM_MOM];
	logic [NUM_MOM-1:0] sat_v, vld_v;

	assign busy = 1'b0;

	tbvm_poly u_poly (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld     (start),
		.base_x  (base_x),
		.base_y  (base_y),
		.top_x   (top_x),
		.top_y   (top_y),
		.vld_out (poly_vld),
		.s       (sums)
	);

	for (genvar g = 0; g < NUM_MOM; g++) begin : g_rnd
		tbvm_round u_round (
			.clk     (clk),
			.arst_n  (arst_n),
			.vld     (poly_vld),
			.s       (sums[g]),
			.k       (RND_K[g]),
			.vld_out (vld_v[g]),
			.value   (mom[g]),
			.sat     (sat_v[g])
		);
	end

	assign done      = vld_v[0];
	assign saturated = |sat_v;
	assign moment_xx = mom[0];
	assign moment_xy = mom[1];
	assign moment_xz = mom[2];
	assign moment_x  = mom[3];
	assign moment_yy = mom[4];
	assign moment_yz = mom[5];
	assign moment_y  = mom[6];
	assign moment_zz = mom[7];
	assign moment_z  = mom[8];
	assign volume    = mom[9];

endmodule
